// File: src/tksi_pkg.sv
`timescale 1ns / 1ps

package tksi_pkg;

    localparam int ENTRIES    = 16;
    localparam int NAME_CHARS = 3;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    localparam int SCORE_W    = 32;
    localparam int LEVEL_W    = 16;
    localparam int INIT_W     = 24;
    localparam int INDEX_W    = 4;
    localparam int RANK_W     = 5;
    localparam int COUNT_W    = 5;

    typedef enum logic [1:0] {
        MODE_SUBMIT = 2'd0,
        MODE_CHECK  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NOP    = 2'd3
    } t_mode;

    typedef struct packed {
        logic                       valid;
        logic signed [SCORE_W-1:0]  score;
        logic        [LEVEL_W-1:0]  level;
        logic        [INIT_W-1:0]   initials;
    } t_entry;

    // What a cell hands to its lower neighbor
    typedef struct packed {
        logic   beaten;
        t_entry ent;
    } t_link;

    // Keep bytes up to the first zero byte, at most NAME_CHARS bytes
    function automatic logic [INIT_W-1:0] clean_initials(input logic [INIT_W-1:0] raw);
        logic [INIT_W-1:0] res;
        logic              keep;
        res  = '0;
        keep = 1'b1;
        for (int i = 0; i < INIT_W / 8; i++) begin
            if (i >= NAME_CHARS || raw[8*i +: 8] == 8'd0) begin
                keep = 1'b0;
            end
            if (keep) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

endpackage

// File: src/tksi_cell.sv
`timescale 1ns / 1ps

module tksi_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  tksi_pkg::t_entry i_new,
    input  tksi_pkg::t_link  i_prev,
    output tksi_pkg::t_link  o_link,
    output logic            o_take
);
    import tksi_pkg::*;

    t_entry r_ent;
    t_entry n_ent;
    logic   beaten;

    // Empty cells are always beaten, so the beaten flags form a thermometer
    assign beaten = !r_ent.valid || ($signed(i_new.score) > $signed(r_ent.score));
    assign o_take = beaten && !i_prev.beaten;

    assign o_link.beaten = beaten;
    assign o_link.ent    = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_wr) begin
            if (i_prev.beaten) begin
                n_ent = i_prev.ent;
            end else if (beaten) begin
                n_ent = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.score    <= n_ent.score;
        r_ent.level    <= n_ent.level;
        r_ent.initials <= n_ent.initials;
    end

endmodule

// File: src/top_k_sorted_insert_table.sv
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                               tuser
// s_axis    in         score[31:0] level[47:32] initials[71:48]         mode[1:0]
//                      index[75:72], zero pad to 80
// m_axis    out        rank[4:0] entry_score[36:5] entry_level[52:37]   entry_valid[0]
//                      entry_initials[76:53] entry_count[81:77], pad 88
//
// One transaction per cycle: the compare-and-shift row of cells settles a sorted
// insertion in the cycle the item is taken, and the result sits in one output register.
// Input is taken while the output register is empty or being drained.
// Synchronous active-low reset empties the table and the output register.

module top_k_sorted_insert_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // score, level, initials, index
    input  logic [1:0]  s_axis_tuser,  // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,  // rank, entry_score, entry_level, entry_initials, entry_count
    output logic        m_axis_tuser   // entry_valid
);
    import tksi_pkg::*;

    t_mode              in_mode;
    logic [INDEX_W-1:0] in_index;
    t_entry             new_ent;
    t_link              links [ENTRIES+1];
    logic [ENTRIES-1:0] takes;
    logic               accept;
    logic               wr;
    logic               any_take;
    logic [CNT_W-1:0]   place_rank;
    t_entry             rd_ent;

    logic               r_ovalid;
    logic [87:0]        r_odata;
    logic               r_ouser;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [87:0]        n_odata;
    logic               n_ouser;

    assign in_mode           = t_mode'(s_axis_tuser);
    assign in_index          = s_axis_tdata[75:72];
    assign new_ent.valid     = 1'b1;
    assign new_ent.score     = s_axis_tdata[31:0];
    assign new_ent.level     = s_axis_tdata[47:32];
    assign new_ent.initials  = clean_initials(s_axis_tdata[71:48]);

    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign wr            = accept && (in_mode == MODE_SUBMIT);

    assign links[0].beaten = 1'b0;
    assign links[0].ent    = new_ent;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        tksi_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (wr),
            .i_new   (new_ent),
            .i_prev  (links[g]),
            .o_link  (links[g+1]),
            .o_take  (takes[g])
        );
    end

    assign any_take = |takes;

    always_comb begin
        place_rank = '0;
        rd_ent     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (takes[i]) begin
                place_rank = CNT_W'(i + 1);
            end
            if (in_index == INDEX_W'(i) && links[i+1].ent.valid) begin
                rd_ent = links[i+1].ent;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (wr && any_take && r_count < CNT_W'(ENTRIES)) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_comb begin
        n_odata = '0;
        n_ouser = 1'b0;
        case (in_mode)
            MODE_SUBMIT, MODE_CHECK: begin
                n_odata[4:0] = RANK_W'(place_rank);
            end
            MODE_READ: begin
                n_ouser        = rd_ent.valid;
                n_odata[36:5]  = rd_ent.score;
                n_odata[52:37] = rd_ent.level;
                n_odata[76:53] = rd_ent.initials;
            end
            default: begin
                n_odata = '0;
            end
        endcase
        n_odata[81:77] = COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (accept) begin
            r_odata <= n_odata;
            r_ouser <= n_ouser;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
